[hdl/ias_pkg.sv]
// Shared constants, types and command codes for the integer insertion sorter.
package ias_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLOSE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t    op;
    value_t value;
  } q_entry_t;

  typedef struct packed {
    logic     avail;
    q_entry_t entry;
  } q_head_t;

endpackage

[hdl/integer_insertion_sort_ascending.sv]
// Top level of the stable ascending insertion sorter for signed integers.
// An element is taken whenever start is high and busy is low; last closes the list.
// Accepted commands wait in a four-entry queue, and the sort row takes one from it
// every cycle while it is not emitting and the queue is not empty, comparing the new
// value against all stored cells at once, so inserts run at one element per cycle
// outside emission. A closing element is inserted like any other; the n results of
// the list then leave one per cycle, each marked by strobe for exactly one cycle,
// with final_res on the last and overflow on all of them when elements past 64 were
// dropped. Once the closing element leaves the queue the row enters its emit state,
// and each result is registered onto sorted_value along with strobe. Results
// cannot be held off. While a list is being emitted the row takes no new elements,
// so the queue fills and busy goes high once it holds four commands.
module integer_insertion_sort_ascending (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ias_pkg::value_t value,
  input  logic            last,
  output logic            strobe,
  output ias_pkg::value_t sorted_value,
  output logic            final_res,
  output logic            overflow
);
  import ias_pkg::*;

  q_head_t head;
  logic    pop;

  ias_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (value),
    .last  (last),
    .busy  (busy),
    .pop   (pop),
    .head  (head)
  );

  ias_chain u_chain (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .strobe       (strobe),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow)
  );

endmodule

[hdl/ias_queue.sv]
// Front end: takes commands, tags them as insert or close, and queues them.
module ias_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ias_pkg::value_t       value,
  input  logic                  last,
  output logic                  busy,
  input  logic                  pop,
  output ias_pkg::q_head_t      head
);
  import ias_pkg::*;

  q_entry_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push;
  q_entry_t           incoming;

  assign busy = (fill == QFILL_W'(QUEUE_DEPTH));
  assign push = start && !busy;

  always_comb begin
    incoming.value = value;
    incoming.op    = last ? OP_CLOSE : OP_INSERT;
    head.avail     = (fill != '0);
    head.entry     = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> fill != '0)
    else $error("queue popped while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QFILL_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

endmodule

[hdl/ias_chain.sv]
// Back end: row of sorted cells with parallel insertion and shift-out emission.
module ias_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  ias_pkg::q_head_t      head,
  output logic                  pop,
  output logic                  strobe,
  output ias_pkg::value_t       sorted_value,
  output logic                  final_res,
  output logic                  overflow
);
  import ias_pkg::*;

  typedef enum logic [1:0] {
    ST_INSERT = 2'b01,
    ST_EMIT   = 2'b10
  } chain_state_t;

  chain_state_t        state;
  logic [COUNT_W-1:0]  count;
  logic                dropped;
  logic                full;
  value_t              cells      [MAX_ITEMS];
  value_t              cells_next [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] greater;
  logic                do_insert;

  assign full      = (count == COUNT_W'(MAX_ITEMS));
  assign pop       = (state == ST_INSERT) && head.avail;
  assign do_insert = pop && !full;

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      greater[i] = (COUNT_W'(i) < count) && (cells[i] > head.entry.value);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      cells_next[i] = cells[i];
    end
    if (state == ST_EMIT) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        cells_next[i] = cells[i + 1];
      end
    end else if (do_insert) begin
      if ((count == '0) || greater[0]) begin
        cells_next[0] = head.entry.value;
      end
      for (int i = 1; i < MAX_ITEMS; i++) begin
        if ((COUNT_W'(i) == count) || greater[i]) begin
          cells_next[i] = greater[i-1] ? cells[i-1] : head.entry.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (state == ST_EMIT) begin
      sorted_value <= cells[0];
      final_res    <= (count == COUNT_W'(1));
      overflow     <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INSERT;
      count   <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_INSERT: begin
          if (pop) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (head.entry.op == OP_CLOSE) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          count  <= count - 1'b1;
          if (count == COUNT_W'(1)) begin
            state   <= ST_INSERT;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= ST_INSERT;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> count != '0)
    else $error("emitting an empty list");
  a_final_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && final_res |=> !strobe)
    else $error("result strobe right after the final result");

endmodule

[dv/integer_insertion_sort_ascending_tb.sv]
// Self-checking testbench for the stable ascending insertion sorter: directed table, then random lists.
module integer_insertion_sort_ascending_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ias_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int N_DIRECTED  = 21;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct {
    value_t sorted_value;
    logic   final_res;
    logic   overflow;
  } sort_result_t;

  typedef struct {
    value_t value;
    logic   last;
    bit     typed;
    value_t want;
  } list_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  value_t value = '0;
  logic   last = 1'b0;
  logic   strobe;
  value_t sorted_value;
  logic   final_res;
  logic   overflow;

  sort_result_t expected_results[$];
  value_t       sorted_row[MAX_ITEMS];
  int unsigned  stored_count = 0;
  bit           lost_flag = 1'b0;

  list_row_t directed_rows[N_DIRECTED];
  int        items_sent = 0;
  int        lists_closed = 0;
  int        overflow_lists = 0;
  int        results_checked = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;

  integer_insertion_sort_ascending dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last         (last),
    .strobe       (strobe),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void absorb(value_t v, logic l);
    int unsigned pos;
    if (stored_count >= MAX_ITEMS) begin
      lost_flag = 1'b1;
    end else begin
      pos = stored_count;
      while (pos > 0 && sorted_row[pos-1] > v) begin
        sorted_row[pos] = sorted_row[pos-1];
        pos--;
      end
      sorted_row[pos] = v;
      stored_count++;
    end
    if (l) begin
      for (int k = 0; k < stored_count; k++) begin
        expected_results.push_back('{sorted_row[k], (k == stored_count - 1), lost_flag});
      end
      lists_closed++;
      if (lost_flag) overflow_lists++;
      stored_count = 0;
      lost_flag = 1'b0;
    end
  endfunction

  task automatic send(value_t v, logic l);
    start <= 1'b1;
    value <= v;
    last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb(v, l);
    items_sent++;
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
    end
  endtask

  task automatic drain_sorted_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    sort_result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction: sorted_value %0d final_res %0b overflow %0b",
                 $realtime, sorted_value, final_res, overflow);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (sorted_value !== want.sorted_value) begin
          $display("%0t: sorted_value expected %0d actual %0d",
                   $realtime, want.sorted_value, sorted_value);
          mismatches++;
        end
        if (final_res !== want.final_res) begin
          $display("%0t: final_res expected %0b actual %0b", $realtime, want.final_res, final_res);
          mismatches++;
        end
        if (overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $realtime, want.overflow, overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d results still outstanding", $realtime, expected_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int     len;
    int     forced_idx;
    int     forced_lengths[3];
    value_t v;

    directed_rows = '{
      '{VALUE_MIN, 1'b1, 1'b1, VALUE_MIN},
      '{VALUE_MAX, 1'b1, 1'b1, VALUE_MAX},
      '{32'sd0, 1'b1, 1'b1, 32'sd0},
      '{-32'sd1, 1'b1, 1'b1, -32'sd1},
      '{32'sd1, 1'b1, 1'b1, 32'sd1},
      '{32'sd7, 1'b0, 1'b0, '0},
      '{-32'sd7, 1'b0, 1'b0, '0},
      '{32'sd7, 1'b0, 1'b0, '0},
      '{VALUE_MAX, 1'b0, 1'b0, '0},
      '{VALUE_MIN, 1'b0, 1'b0, '0},
      '{32'sd0, 1'b0, 1'b0, '0},
      '{32'sd7, 1'b1, 1'b0, '0},
      '{32'h5555_5555, 1'b0, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      '{32'sd3, 1'b0, 1'b0, '0},
      '{32'sd2, 1'b0, 1'b0, '0},
      '{32'sd1, 1'b0, 1'b0, '0},
      '{32'sd0, 1'b1, 1'b0, '0},
      '{-32'sd2, 1'b0, 1'b0, '0},
      '{-32'sd1, 1'b1, 1'b0, '0}
    };
    forced_lengths = '{64, 65, 68};
    forced_idx = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 24);

    foreach (directed_rows[i]) begin
      send(directed_rows[i].value, directed_rows[i].last);
      if (directed_rows[i].typed) begin
        void'(expected_results.pop_back());
        expected_results.push_back('{directed_rows[i].want, 1'b1, 1'b0});
      end
      pace();
    end
    drain_sorted_results();

    while (items_sent < ITEM_TARGET) begin
      if (forced_idx < 3) begin
        len = forced_lengths[forced_idx];
        forced_idx++;
      end else begin
        case ($urandom_range(0, 19))
          16, 17, 18: len = $urandom_range(9, 24);
          19:         len = $urandom_range(56, 72);
          default:    len = $urandom_range(1, 8);
        endcase
      end
      for (int i = 1; i <= len; i++) begin
        case ($urandom_range(0, 9))
          0:       v = VALUE_MIN;
          1:       v = VALUE_MAX;
          2:       v = value_t'(int'($urandom_range(0, 8)) - 4);
          3, 4:    v = value_t'(int'($urandom_range(0, 200)) - 100);
          default: v = value_t'($urandom);
        endcase
        send(v, (i == len));
        pace();
      end
      if ($urandom_range(0, 7) == 0) drain_sorted_results();
    end

    drain_sorted_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d elements in %0d lists, %0d of them overflowed; checked %0d sorted results.",
             items_sent, lists_closed, overflow_lists, results_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
